@@ hdl/ctep_pkg.sv @@
// Package for the cubic trajectory extrapolator: sizes, the job record that
// passes from the front to the back, and the back state encoding.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ctep_pkg;

   localparam int WINDOW      = 4;
   localparam int COORD_BITS  = 12;
   localparam int FRAC_BITS   = 8;
   localparam int PRED_X_BITS = 14;
   localparam int PRED_Y_BITS = 32;

   localparam int IDXW = $clog2(WINDOW);
   localparam int CNTW = $clog2(WINDOW + 1);
   // Predicted x and its distance to any window x both fit in this signed width.
   localparam int PXW  = COORD_BITS + 2;
   localparam int DW   = COORD_BITS + 1;
   localparam int YW   = COORD_BITS + FRAC_BITS;
   localparam int NUMW = YW + (WINDOW - 1) * DW;
   localparam int DENW = (WINDOW - 1) * COORD_BITS;
   localparam int SUMW = NUMW + IDXW + 1;
   localparam int DCW  = $clog2(NUMW);

   localparam int QDEPTH = 2;
   localparam int QPTRW  = $clog2(QDEPTH);
   localparam int QCNTW  = $clog2(QDEPTH + 1);

   typedef logic [WINDOW-1:0][COORD_BITS-1:0] coord_row_type;

   typedef struct packed {
      coord_row_type         wx;
      coord_row_type         wy;
      logic signed [PXW-1:0] px;
      logic                  singular;
   } job_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SETUP = 6'b000010,
      S_MUL   = 6'b000100,
      S_DIV   = 6'b001000,
      S_ACC   = 6'b010000,
      S_DONE  = 6'b100000
   } back_state_type;

endpackage
`default_nettype wire

@@ hdl/ctep_front.sv @@
// Front part: holds the sliding window of points, accepts input
// transactions and builds one job per prediction. Uses ctep_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ctep_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [ctep_pkg::COORD_BITS-1:0] req_point_x,
   input  wire logic [ctep_pkg::COORD_BITS-1:0] req_point_y,
   input  wire logic                         queue_full,
   output logic                              push,
   output ctep_pkg::job_type                 push_job
);
   import ctep_pkg::*;

   coord_row_type   wx_ff, wx_in, wy_ff, wy_in;
   logic [CNTW-1:0] fill_ff, fill_in;
   logic            accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      wx_in   = wx_ff;
      wy_in   = wy_ff;
      fill_in = fill_ff;
      if (fill_ff == CNTW'(WINDOW)) begin
         for (int k = 0; k < WINDOW - 1; k++) begin
            wx_in[k] = wx_ff[k+1];
            wy_in[k] = wy_ff[k+1];
         end
         wx_in[WINDOW-1] = req_point_x;
         wy_in[WINDOW-1] = req_point_y;
      end else begin
         wx_in[fill_ff[IDXW-1:0]] = req_point_x;
         wy_in[fill_ff[IDXW-1:0]] = req_point_y;
         fill_in = fill_ff + CNTW'(1);
      end
   end

   always_comb begin
      push_job.wx = wx_in;
      push_job.wy = wy_in;
      push_job.px = $signed(PXW'({wx_in[WINDOW-1], 1'b0}))
                  - $signed(PXW'(wx_in[WINDOW-2]));
      push_job.singular = 1'b0;
      for (int a = 0; a < WINDOW; a++) begin
         for (int b = a + 1; b < WINDOW; b++) begin
            if (wx_in[a] == wx_in[b]) begin
               push_job.singular = 1'b1;
            end
         end
      end
   end

   assign push = accept && (fill_in == CNTW'(WINDOW));

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         wx_ff   <= '0;
         wy_ff   <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
         wx_ff   <= wx_in;
         wy_ff   <= wy_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/ctep_queue.sv @@
// Short job queue between the front and the back parts.
// Uses ctep_pkg for the job record and the depth.
`timescale 1ns / 1ps
`default_nettype none
module ctep_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire ctep_pkg::job_type push_job,
   input  wire logic        pop,
   output ctep_pkg::job_type pop_job,
   output logic             full,
   output logic             empty
);
   import ctep_pkg::*;

   job_type          entry_ff [QDEPTH];
   logic [QPTRW-1:0] wr_ff, rd_ff;
   logic [QCNTW-1:0] count_ff;

   assign full    = (count_ff == QCNTW'(QDEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == QPTRW'(QDEPTH - 1)) ? '0 : wr_ff + QPTRW'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == QPTRW'(QDEPTH - 1)) ? '0 : rd_ff + QPTRW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNTW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNTW'(1);
         end
      end
   end

endmodule
`default_nettype wire

@@ hdl/ctep_back.sv @@
// Back part: evaluates the Lagrange sum for one job with a shared pair of multipliers
// and a restoring divider, then saturates and holds the result.
// Uses ctep_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ctep_back (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        queue_empty,
   output logic             pop,
   input  wire ctep_pkg::job_type pop_job,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [ctep_pkg::PRED_X_BITS-1:0] rsp_pred_x,
   output logic signed [ctep_pkg::PRED_Y_BITS-1:0] rsp_pred_y,
   output logic             rsp_singular,
   output logic             rsp_saturated
);
   import ctep_pkg::*;

   back_state_type         state_ff, state_in;
   job_type                job_ff;
   logic [IDXW-1:0]        i_ff, j_ff;
   logic [NUMW-1:0]        num_ff, q_ff;
   logic [DENW-1:0]        den_ff;
   logic [DENW:0]          rem_ff;
   logic                   neg_ff;
   logic [DCW-1:0]         bit_ff;
   logic signed [SUMW-1:0] sum_ff;
   logic                   out_free;

   logic signed [PXW-1:0]          d;
   logic signed [COORD_BITS:0]     e;
   logic [DW-1:0]                  dmag;
   logic [COORD_BITS-1:0]          emag;
   logic [DENW:0]                  cand;
   logic                           take;
   logic [NUMW:0]                  qr;
   logic signed [SUMW-1:0]         term;
   logic                           fits;
   logic [PRED_Y_BITS-1:0]         py;

   assign out_free = !rsp_valid || !rsp_stall;
   assign pop      = state_ff == S_IDLE && !queue_empty;

   always_comb begin
      d    = job_ff.px - $signed(PXW'(job_ff.wx[j_ff]));
      e    = $signed({1'b0, job_ff.wx[i_ff]}) - $signed({1'b0, job_ff.wx[j_ff]});
      dmag = d[PXW-1] ? DW'(-d) : DW'(d);
      emag = e[COORD_BITS] ? COORD_BITS'(-e) : COORD_BITS'(e);
      cand = {rem_ff[DENW-1:0], num_ff[NUMW-1]};
      take = cand >= {1'b0, den_ff};
      qr   = {1'b0, q_ff} + (({rem_ff[DENW-1:0], 1'b0} >= {1'b0, den_ff})
                             ? (NUMW+1)'(1) : '0);
      term = neg_ff ? -$signed(SUMW'(qr)) : $signed(SUMW'(qr));
      fits = (&sum_ff[SUMW-1:PRED_Y_BITS-1]) || !(|sum_ff[SUMW-1:PRED_Y_BITS-1]);
      if (fits) begin
         py = sum_ff[PRED_Y_BITS-1:0];
      end else begin
         py = sum_ff[SUMW-1] ? {1'b1, {(PRED_Y_BITS-1){1'b0}}}
                             : {1'b0, {(PRED_Y_BITS-1){1'b1}}};
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (!queue_empty) begin
                     state_in = pop_job.singular ? S_DONE : S_SETUP;
                  end
         S_SETUP: state_in = S_MUL;
         S_MUL:   if (j_ff == IDXW'(WINDOW - 1)) begin
                     state_in = S_DIV;
                  end
         S_DIV:   if (bit_ff == '0) begin
                     state_in = S_ACC;
                  end
         S_ACC:   state_in = (i_ff == IDXW'(WINDOW - 1)) ? S_DONE : S_SETUP;
         S_DONE:  if (out_free) begin
                     state_in = S_IDLE;
                  end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_DONE && out_free) begin
            rsp_valid <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            job_ff <= pop_job;
            i_ff   <= '0;
            sum_ff <= '0;
         end
         S_SETUP: begin
            num_ff <= NUMW'({job_ff.wy[i_ff], {FRAC_BITS{1'b0}}});
            den_ff <= DENW'(1);
            neg_ff <= 1'b0;
            j_ff   <= '0;
         end
         S_MUL: begin
            if (j_ff != i_ff) begin
               num_ff <= NUMW'(num_ff * dmag);
               den_ff <= DENW'(den_ff * emag);
               neg_ff <= neg_ff ^ d[PXW-1] ^ e[COORD_BITS];
            end
            j_ff   <= j_ff + IDXW'(1);
            rem_ff <= '0;
            q_ff   <= '0;
            bit_ff <= DCW'(NUMW - 1);
         end
         S_DIV: begin
            rem_ff <= take ? cand - {1'b0, den_ff} : cand;
            q_ff   <= {q_ff[NUMW-2:0], take};
            num_ff <= {num_ff[NUMW-2:0], 1'b0};
            bit_ff <= bit_ff - DCW'(1);
         end
         S_ACC: begin
            sum_ff <= sum_ff + term;
            i_ff   <= i_ff + IDXW'(1);
         end
         S_DONE: begin
            if (out_free) begin
               rsp_pred_x    <= PRED_X_BITS'(job_ff.px);
               rsp_pred_y    <= py;
               rsp_singular  <= job_ff.singular;
               rsp_saturated <= !fits;
            end
         end
         default: ;
      endcase
   end

   // A singular fit always reports zero and no clipping.
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_pred_y == '0 && !rsp_saturated)
      else $error("singular result carries a value");

   // A clipped result sits exactly at one of the two limits.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_pred_y == {1'b1, {(PRED_Y_BITS-1){1'b0}}} ||
         rsp_pred_y == {1'b0, {(PRED_Y_BITS-1){1'b1}}})
      else $error("saturated result not at a limit");

   // The divisor is a product of nonzero distances.
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> den_ff != '0)
      else $error("zero divisor in Lagrange term");

endmodule
`default_nettype wire

@@ hdl/cubic_trajectory_extrapolator.sv @@
// Top level of the cubic trajectory extrapolator: front, job queue and back.
// Uses ctep_pkg, ctep_front, ctep_queue and ctep_back.
//
//   Channel | Ports                                  | Direction
//   --------+----------------------------------------+-----------
//   req     | req_valid req_stall req_point_x/_y     | in
//   rsp     | rsp_valid rsp_stall rsp_pred_x/_y      | out
//           | rsp_singular rsp_saturated             |
//
// The front stores every point; from the fourth point on, each transaction
// becomes a job in a two-entry queue. Per Lagrange term a regular job passes
// in the back through setup, multiply steps over the window, the restoring
// divider's one-bit-per-cycle loop and an accumulate step, between a dispatch
// and a result step; a singular job goes from dispatch straight to result.
// Reset is synchronous and empties the window, the queue and the result slot.
// req_stall rises only when the queue is full; the result register lets the
// back start the next job while a result waits on rsp_stall.
`timescale 1ns / 1ps
`default_nettype none
module cubic_trajectory_extrapolator (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire logic [ctep_pkg::COORD_BITS-1:0] req_point_x,
   input  wire logic [ctep_pkg::COORD_BITS-1:0] req_point_y,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output logic signed [ctep_pkg::PRED_X_BITS-1:0] rsp_pred_x,
   output logic signed [ctep_pkg::PRED_Y_BITS-1:0] rsp_pred_y,
   output logic      rsp_singular,
   output logic      rsp_saturated
);
   import ctep_pkg::*;

   // Jobs carry the whole window, the predicted x and the repeat flag, so
   // the back never looks at the front's registers.
   job_type push_job, pop_job;
   logic    push, pop, queue_full, queue_empty;

   ctep_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   ctep_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // The back runs the sum in exact integers, rounds each term half away
   // from zero and clips the total to the 32-bit Q.8 range.
   ctep_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .pop           (pop),
      .pop_job       (pop_job),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pred_x    (rsp_pred_x),
      .rsp_pred_y    (rsp_pred_y),
      .rsp_singular  (rsp_singular),
      .rsp_saturated (rsp_saturated)
   );

endmodule
`default_nettype wire
